// ===== hw/rtl/mcpt_pkg.sv =====
// Shared types and constants for the MIDI clock position tracker.
`default_nettype none

package mcpt_pkg;

   localparam int TICK_WIDTH_DEFAULT = 16;
   localparam int BAR_WIDTH_DEFAULT  = 16;

   // MIDI real-time and system common status bytes
   localparam logic [7:0] STATUS_CLOCK = 8'hF8;
   localparam logic [7:0] STATUS_START = 8'hFA;
   localparam logic [7:0] STATUS_STOP  = 8'hFC;
   localparam logic [7:0] STATUS_SPP   = 8'hF2;

   // 60 * 1024, beats per minute scaled by 1024 over milliseconds per beat
   localparam logic [15:0] TEMPO_NUMERATOR = 16'd61440;
   localparam logic [15:0] TEMPO_SATURATED = 16'hFFFF;
   localparam logic [4:0]  LAST_CLOCK_IN_BEAT = 5'd23;
   localparam logic [2:0]  LAST_STEP = 3'd4;

   localparam int DIV_STEPS     = 16;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_HOME,
      OP_STOP,
      OP_SPP,
      OP_CLOCK,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [13:0] pos;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic        stop_seen;
      logic        beat_pulse;
      logic [15:0] tempo_value;
      logic [4:0]  clock_in_beat;
      logic [15:0] bar_number;
      logic [2:0]  beat_number;
      logic [2:0]  sixteenth_step;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mcpt_front.sv =====
// Front end: accepts requests, holds the follow-enable register, classifies messages.
`default_nettype none

module mcpt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic              req_action,
   input  wire logic [7:0]        req_status,
   input  wire logic [6:0]        req_data_low,
   input  wire logic [6:0]        req_data_high,
   input  wire logic              q_full,
   output logic                   q_push,
   output mcpt_pkg::cmd_type      q_cmd
);
   import mcpt_pkg::*;

   logic follow_ff;
   logic follow_in;

   assign follow_in = csr_we ? csr_wdata : follow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         follow_ff <= 1'b1;
      end else begin
         follow_ff <= follow_in;
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      q_cmd.pos = {req_data_high, req_data_low};
      if (!req_action) begin
         q_cmd.op = OP_TICK;
      end else if (!follow_ff) begin
         q_cmd.op = OP_NONE;
      end else begin
         case (req_status)
            STATUS_START: q_cmd.op = OP_HOME;
            STATUS_STOP:  q_cmd.op = OP_STOP;
            STATUS_SPP:   q_cmd.op = OP_SPP;
            STATUS_CLOCK: q_cmd.op = OP_CLOCK;
            default:      q_cmd.op = OP_NONE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mcpt_queue.sv =====
// Two-entry command queue between the front end and the back end.
`default_nettype none

module mcpt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mcpt_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output mcpt_pkg::cmd_type      head_cmd
);
   import mcpt_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   cmd_type                q_mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   // depth is a power of two, pointers wrap naturally
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = q_mem_ff[rd_ptr_ff];

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mcpt_back.sv =====
// Back end: position state, iterative tempo divider and response register.
`default_nettype none

module mcpt_back #(
   parameter int TICK_WIDTH = mcpt_pkg::TICK_WIDTH_DEFAULT,
   parameter int BAR_WIDTH  = mcpt_pkg::BAR_WIDTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire mcpt_pkg::cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output mcpt_pkg::result_type   rsp_result
);
   import mcpt_pkg::*;

   back_state_type            state_ff, state_in;
   logic [TICK_WIDTH-1:0]     elapsed_ff, elapsed_in;
   logic [4:0]                phase_ff, phase_in;
   logic [2:0]                step_ff, step_in;
   logic [2:0]                beat_ff, beat_in;
   logic [BAR_WIDTH-1:0]      bar_ff, bar_in;
   logic [15:0]               tempo_ff, tempo_in;
   logic [TICK_WIDTH-1:0]     divisor_ff, divisor_in;
   logic [TICK_WIDTH-1:0]     rem_ff, rem_in;
   logic [15:0]               quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                result_ff, result_in;

   logic                      slot_free;
   logic                      start_div;
   logic                      load_out;
   logic                      div_step;
   logic                      finish;
   logic [4:0]                phase_inc;
   logic                      phase_wrap;
   logic [TICK_WIDTH:0]       trial;
   logic [TICK_WIDTH:0]       diff;
   logic [BAR_WIDTH+9:0]      spp_bar_ext;
   logic [BAR_WIDTH+15:0]     bar_ext;
   logic [2:0]                step_adv;
   logic [2:0]                beat_adv;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign phase_inc  = (phase_ff == LAST_CLOCK_IN_BEAT) ? 5'd0 : phase_ff + 5'd1;
   assign phase_wrap = (phase_inc == 5'd0);
   assign step_adv   = (step_ff == LAST_STEP) ? 3'd1 : step_ff + 3'd1;
   assign beat_adv   = (beat_ff == LAST_STEP) ? 3'd1 : beat_ff + 3'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_div) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      start_div = 1'b0;
      div_step  = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop     = q_valid && slot_free;
            start_div = q_valid && slot_free && (q_cmd.op == OP_CLOCK) && phase_wrap;
         end
         ST_DIVIDE: div_step = 1'b1;
         ST_FINISH: finish   = slot_free;
         default: begin
            q_pop = 1'b0;
         end
      endcase
      load_out = (q_pop && !start_div) || finish;
   end

   // restoring divide, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[15]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign spp_bar_ext = (BAR_WIDTH + 10)'(q_cmd.pos[13:4]);

   always_comb begin
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      beat_in    = beat_ff;
      bar_in     = bar_ff;
      tempo_in   = tempo_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;

      if (q_pop) begin
         case (q_cmd.op)
            OP_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            OP_HOME, OP_STOP: begin
               elapsed_in = '0;
               phase_in   = 5'd0;
               step_in    = 3'd1;
               beat_in    = 3'd1;
               bar_in     = BAR_WIDTH'(1);
            end
            OP_SPP: begin
               elapsed_in = '0;
               phase_in   = 5'(q_cmd.pos[1:0]) * 5'd6;
               step_in    = {1'b0, q_cmd.pos[1:0]} + 3'd1;
               beat_in    = {1'b0, q_cmd.pos[3:2]} + 3'd1;
               bar_in     = spp_bar_ext[BAR_WIDTH-1:0] + BAR_WIDTH'(1);
            end
            OP_CLOCK: begin
               phase_in = phase_inc;
               if (phase_inc inside {5'd0, 5'd6, 5'd12, 5'd18}) begin
                  step_in = step_adv;
               end
               if (phase_wrap) begin
                  beat_in = beat_adv;
                  if (beat_ff == LAST_STEP) begin
                     bar_in = bar_ff + BAR_WIDTH'(1);
                  end
                  divisor_in = elapsed_ff;
                  elapsed_in = '0;
                  rem_in     = '0;
                  quo_in     = TEMPO_NUMERATOR;
                  cnt_in     = DIV_CNT_WIDTH'(DIV_STEPS - 1);
               end
            end
            default: begin
               elapsed_in = elapsed_ff;
            end
         endcase
      end

      if (div_step) begin
         if (!diff[TICK_WIDTH]) begin
            rem_in = diff[TICK_WIDTH-1:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[TICK_WIDTH-1:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end

      if (finish) begin
         tempo_in = (divisor_ff == '0) ? TEMPO_SATURATED : quo_ff;
      end
   end

   assign bar_ext = (BAR_WIDTH + 16)'(bar_in);

   always_comb begin
      result_in.sixteenth_step = step_in;
      result_in.beat_number    = beat_in;
      result_in.bar_number     = bar_ext[15:0];
      result_in.clock_in_beat  = phase_in;
      result_in.tempo_value    = tempo_in;
      result_in.beat_pulse     = finish;
      result_in.stop_seen      = q_pop && (q_cmd.op == OP_STOP);
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
         phase_ff     <= 5'd0;
         step_ff      <= 3'd1;
         beat_ff      <= 3'd1;
         bar_ff       <= BAR_WIDTH'(1);
         tempo_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         beat_ff      <= beat_in;
         bar_ff       <= bar_in;
         tempo_ff     <= tempo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      if (load_out) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = result_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) phase_ff <= LAST_CLOCK_IN_BEAT)
      else $error("clock-in-beat out of range");
   assert property (@(posedge clock) disable iff (reset)
      step_ff != 3'd0 && step_ff <= LAST_STEP && beat_ff != 3'd0 && beat_ff <= LAST_STEP)
      else $error("step or beat out of range");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FINISH |=> $stable(tempo_ff))
      else $error("tempo changed outside divide finish");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !q_pop)
      else $error("command popped while divider busy");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/midi_clock_position_tracker.sv =====
// Top level of the MIDI beat clock and song position tracker.
`default_nettype none

// Follows MIDI beat clock: each request is a one millisecond tick (tuser 0)
// or a received MIDI message (tuser 1), and each request yields exactly one
// response carrying the position after it (bar, beat 1..4, sixteenth 1..4,
// clock-in-beat 0..23), the last measured tempo (61440 / ms per beat,
// 65535 when no time elapsed) and the beat-pulse and stop flags. Start and
// stop return to bar 1 beat 1 step 1; song position loads from its 14-bit
// sixteenth count; csr_wdata low disables message following (ticks still
// count). Requests go through a two-entry queue to the back end: ticks and
// most messages are handled directly from idle, while a clock that begins a
// new beat keeps the back end busy through the bit-serial tempo divider
// (start, 16 steps, finish). Response is registered, so the next request is
// taken while a response waits.
module midi_clock_position_tracker #(
   parameter int TICK_WIDTH = mcpt_pkg::TICK_WIDTH_DEFAULT,
   parameter int BAR_WIDTH  = mcpt_pkg::BAR_WIDTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // follow-enable register write
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,  // status_byte[7:0], data_low[14:8], data_high[21:15]
   input  wire logic         req_tuser,  // action
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,  // sixteenth_step[2:0], beat_number[5:3],
                                         // bar_number[21:6], clock_in_beat[26:22],
                                         // tempo_value[42:27]
   output logic [1:0]        rsp_tuser   // beat_pulse[0], stop_seen[1]
);
   import mcpt_pkg::*;

   logic        q_full;
   logic        q_push;
   cmd_type     push_cmd;
   logic        q_pop;
   logic        q_valid;
   cmd_type     head_cmd;
   result_type  result;

   // classify and enqueue
   mcpt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_action    (req_tuser),
      .req_status    (req_tdata[7:0]),
      .req_data_low  (req_tdata[14:8]),
      .req_data_high (req_tdata[21:15]),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // decouples front from a busy divider
   mcpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   // position update, tempo divide, response register
   mcpt_back #(
      .TICK_WIDTH (TICK_WIDTH),
      .BAR_WIDTH  (BAR_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {5'b0, result.tempo_value, result.clock_in_beat,
                       result.bar_number, result.beat_number, result.sixteenth_step};
   assign rsp_tuser = {result.stop_seen, result.beat_pulse};

endmodule

`default_nettype wire
